>>> hdl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int MAX_BLOCKS_DEF      = 32;
	localparam int ALIGN_BYTES_DEF     = 4;
	localparam int HEADER_BYTES_DEF    = 8;
	localparam int ARENA_ADDR_BITS_DEF = 20;

	localparam int LEN_W  = 21;
	localparam int ADDR_W = 32;

	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_FREE    = 2'd1,
		CMD_REALLOC = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOOP      = 3'd1,
		ST_NO_SPACE  = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic [0:0] {
		REG_HEAP_BASE   = 1'b0,
		REG_HEAP_LENGTH = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]        command;
		logic              address_is_null;
		logic [ADDR_W-1:0] payload_address;
		logic [LEN_W-1:0]  request_bytes;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [ADDR_W-1:0] result_address;
		logic [LEN_W-1:0]  granted_bytes;
		logic              moved;
		logic [LEN_W-1:0]  free_bytes;
	} rsp_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_SLOT,
		S_FIND_RD,
		S_FIND_CHK,
		S_RL_NEXT_RD,
		S_RL_ROOM,
		S_PL_FIRST_RD,
		S_PL_FIRST_CHK,
		S_PL_RD,
		S_PL_NEXT_RD,
		S_PL_CHK,
		S_PL_WR,
		S_UL_PREV_WR,
		S_UL_DONE,
		S_DONE
	} state_t;

endpackage

>>> hdl/ffha_table.sv
// ----------------------------------------------------------------------------
// ffha_table
// Block table memory: offset, length and link per slot, one read port.
// ----------------------------------------------------------------------------
module ffha_table #(
	parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF,
	parameter int OFF_W      = ffha_pkg::ARENA_ADDR_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(MAX_BLOCKS)-1:0] waddr,
	input  logic [OFF_W-1:0]              woff,
	input  logic [ffha_pkg::LEN_W-1:0]    wlen,
	input  logic [$clog2(MAX_BLOCKS)-1:0] wlink,
	input  logic                          we_link_only,
	input  logic [$clog2(MAX_BLOCKS)-1:0] raddr,
	output logic [OFF_W-1:0]              roff,
	output logic [ffha_pkg::LEN_W-1:0]    rlen,
	output logic [$clog2(MAX_BLOCKS)-1:0] rlink
);
	localparam int IW = $clog2(MAX_BLOCKS);

	logic [OFF_W-1:0]           off_mem  [MAX_BLOCKS];
	logic [ffha_pkg::LEN_W-1:0] len_mem  [MAX_BLOCKS];
	logic [IW-1:0]              link_mem [MAX_BLOCKS];

	always_ff @(posedge clk) begin
		if (we) begin
			off_mem[waddr] <= woff;
			len_mem[waddr] <= wlen;
		end
		if (we || we_link_only) begin
			link_mem[waddr] <= wlink;
		end
		roff  <= off_mem[raddr];
		rlen  <= len_mem[raddr];
		rlink <= link_mem[raddr];
	end
endmodule

>>> hdl/first_fit_heap_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit allocator over one arena, kept as an address-ordered block list.
// ----------------------------------------------------------------------------
// the result strobe follows the transfer, later by each block that a lookup walk or
//   a placement walk visits; a moving reallocate does a lookup walk, a placement
//   walk and a second lookup walk to unlink the old block
// throughput: one command at a time, busy high until the result strobe
// reset: heap empty, base 0, length 65536; the receiver cannot stall
module first_fit_heap_allocator_top #(
	parameter int MAX_BLOCKS      = ffha_pkg::MAX_BLOCKS_DEF,
	parameter int ALIGN_BYTES     = ffha_pkg::ALIGN_BYTES_DEF,
	parameter int HEADER_BYTES    = ffha_pkg::HEADER_BYTES_DEF,
	parameter int ARENA_ADDR_BITS = ffha_pkg::ARENA_ADDR_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  ffha_pkg::req_t             req,
	output logic                       done,
	output ffha_pkg::rsp_t             rsp,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [ffha_pkg::ADDR_W-1:0] cfg_data
);
	localparam int IW  = $clog2(MAX_BLOCKS);
	localparam int OW  = ARENA_ADDR_BITS;
	localparam int LW  = ffha_pkg::LEN_W;
	localparam int AW  = ffha_pkg::ADDR_W;
	localparam int CW  = 34;
	localparam logic [CW-1:0] CAP  = CW'(64'd1 << ARENA_ADDR_BITS);
	localparam logic [CW-1:0] HDR  = CW'(HEADER_BYTES);
	localparam logic [CW-1:0] ALM1 = CW'(ALIGN_BYTES - 1);
	localparam logic [CW-1:0] ALGN = CW'(ALIGN_BYTES);

	ffha_pkg::state_t state_q, state_d;

	logic [AW-1:0]  base_q;
	logic [LW-1:0]  len_q;
	logic [MAX_BLOCKS-1:0] used_q;
	logic           first_empty_q;
	logic [IW-1:0]  first_q;
	logic [LW-1:0]  unused_q;

	ffha_pkg::req_t req_q;
	logic [CW-1:0]  n_q;
	logic [OW-1:0]  off_q;
	logic [IW-1:0]  slot_q;
	logic           slot_ok_q;
	logic [IW-1:0]  h_q, p_q, nx_q;
	logic           p_none_q;
	logic [IW:0]    cnt_q;
	logic [OW-1:0]  hoff_q;
	logic [LW-1:0]  hlen_q;
	logic [IW-1:0]  hlink_q;
	logic [1:0]     mode_q;
	logic           second_q;
	ffha_pkg::rsp_t rsp_q;
	logic           poff_q;

	localparam logic [1:0] M_FREE = 2'd0, M_REAL = 2'd1, M_UNLINK = 2'd2;

	logic           t_we, t_wl;
	logic [IW-1:0]  t_wa, t_wlink, t_ra;
	logic [OW-1:0]  t_woff, t_roff;
	logic [LW-1:0]  t_wlen, t_rlen;
	logic [IW-1:0]  t_rlink;

	ffha_table #(.MAX_BLOCKS(MAX_BLOCKS), .OFF_W(OW)) u_table (
		.clk(clk), .we(t_we), .waddr(t_wa), .woff(t_woff), .wlen(t_wlen),
		.wlink(t_wlink), .we_link_only(t_wl), .raddr(t_ra),
		.roff(t_roff), .rlen(t_rlen), .rlink(t_rlink)
	);

	logic [CW-1:0] bsize;
	logic [CW-1:0] end_c, gap_to, gap_c;
	logic          gap_fit;
	logic          last_c;
	logic [IW-1:0] fs;
	logic          fs_ok;

	always_comb begin
		bsize = ((CW'(req_q.request_bytes) + ALM1) / ALGN) * ALGN + HDR;
	end

	always_comb begin
		fs = '0;
		fs_ok = 1'b0;
		for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				fs = IW'(i);
				fs_ok = 1'b1;
			end
		end
	end

	// shared compare unit: gap from end of block h (its start in S_RL_ROOM) to next offset or arena end
	always_comb begin
		last_c = (hlink_q == h_q);
		end_c  = (state_q == ffha_pkg::S_RL_ROOM) ? CW'(hoff_q)
			: CW'(hoff_q) + CW'(hlen_q);
		gap_to = last_c ? CW'(len_q) : CW'(t_roff);
		gap_c  = (gap_to >= end_c) ? gap_to - end_c : '0;
		gap_fit = gap_c >= n_q;
	end

	logic [AW-1:0] tgt_off;
	assign tgt_off = req_q.payload_address - AW'(HEADER_BYTES) - base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffha_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ffha_pkg::S_IDLE:
				if (start) state_d = ffha_pkg::S_DECODE;
			ffha_pkg::S_DECODE: begin
				state_d = ffha_pkg::S_DONE;
				case (req_q.command)
					ffha_pkg::CMD_ALLOC:
						if (req_q.request_bytes != '0 && bsize <= CW'(unused_q)
							&& fs_ok)
							state_d = ffha_pkg::S_PL_FIRST_RD;
					ffha_pkg::CMD_FREE:
						if (!req_q.address_is_null && !first_empty_q)
							state_d = ffha_pkg::S_FIND_RD;
					ffha_pkg::CMD_REALLOC:
						if (req_q.address_is_null) begin
							if (req_q.request_bytes != '0 && bsize <= CW'(unused_q)
								&& fs_ok)
								state_d = ffha_pkg::S_PL_FIRST_RD;
						end else if (req_q.request_bytes == '0) begin
							if (!first_empty_q) state_d = ffha_pkg::S_FIND_RD;
						end else if (bsize <= CW'(unused_q) && !first_empty_q) begin
							state_d = ffha_pkg::S_FIND_RD;
						end
					default: state_d = ffha_pkg::S_DONE;
				endcase
			end
			ffha_pkg::S_FIND_RD: state_d = ffha_pkg::S_FIND_CHK;
			ffha_pkg::S_FIND_CHK:
				if (t_roff == tgt_off[OW-1:0] && tgt_off[AW-1:OW] == '0) begin
					if (mode_q == M_REAL) state_d = ffha_pkg::S_RL_NEXT_RD;
					else state_d = ffha_pkg::S_UL_PREV_WR;
				end else if (t_rlink == h_q || cnt_q == (IW+1)'(MAX_BLOCKS - 1)) begin
					state_d = ffha_pkg::S_DONE;
				end else begin
					state_d = ffha_pkg::S_FIND_RD;
				end
			ffha_pkg::S_RL_NEXT_RD: state_d = ffha_pkg::S_RL_ROOM;
			ffha_pkg::S_RL_ROOM:
				if (gap_fit) state_d = ffha_pkg::S_DONE;
				else if (!slot_ok_q) state_d = ffha_pkg::S_FIND_RD;
				else state_d = ffha_pkg::S_PL_FIRST_RD;
			ffha_pkg::S_SLOT: state_d = ffha_pkg::S_DONE;
			ffha_pkg::S_PL_FIRST_RD:
				if (first_empty_q) state_d = ffha_pkg::S_PL_WR;
				else state_d = ffha_pkg::S_PL_FIRST_CHK;
			ffha_pkg::S_PL_FIRST_CHK:
				if (CW'(t_roff) >= n_q) state_d = ffha_pkg::S_PL_WR;
				else state_d = ffha_pkg::S_PL_NEXT_RD;
			ffha_pkg::S_PL_RD: state_d = ffha_pkg::S_PL_NEXT_RD;
			ffha_pkg::S_PL_NEXT_RD: state_d = ffha_pkg::S_PL_CHK;
			ffha_pkg::S_PL_CHK:
				if (gap_fit) state_d = ffha_pkg::S_PL_WR;
				else if (last_c || cnt_q == (IW+1)'(MAX_BLOCKS - 1))
					state_d = second_q ? ffha_pkg::S_FIND_RD : ffha_pkg::S_DONE;
				else state_d = ffha_pkg::S_PL_RD;
			ffha_pkg::S_PL_WR:
				state_d = second_q ? ffha_pkg::S_FIND_RD : ffha_pkg::S_DONE;
			ffha_pkg::S_UL_PREV_WR: state_d = ffha_pkg::S_UL_DONE;
			ffha_pkg::S_UL_DONE: state_d = ffha_pkg::S_DONE;
			ffha_pkg::S_DONE: state_d = ffha_pkg::S_IDLE;
			default: state_d = ffha_pkg::S_IDLE;
		endcase
	end

	// table port control
	always_comb begin
		t_we = 1'b0;
		t_wl = 1'b0;
		t_wa = h_q;
		t_woff = off_q;
		t_wlen = LW'(n_q);
		t_wlink = h_q;
		t_ra = h_q;
		case (state_q)
			ffha_pkg::S_RL_NEXT_RD, ffha_pkg::S_PL_NEXT_RD: t_ra = hlink_q;
			ffha_pkg::S_PL_FIRST_RD: t_ra = first_q;
			ffha_pkg::S_RL_ROOM:
				if (gap_fit) begin
					t_we = 1'b1; t_wa = h_q; t_woff = hoff_q;
					t_wlen = LW'(n_q); t_wlink = hlink_q;
				end
			ffha_pkg::S_PL_FIRST_CHK:
				if (CW'(t_roff) >= n_q) begin
					t_we = 1'b1; t_wa = slot_q; t_woff = '0; t_wlink = first_q;
				end
			ffha_pkg::S_PL_CHK:
				if (gap_fit) begin
					t_we = 1'b1; t_wa = slot_q; t_woff = OW'(end_c);
					t_wlink = last_c ? slot_q : hlink_q;
				end
			ffha_pkg::S_PL_WR:
				if (first_empty_q) begin
					t_we = 1'b1; t_wa = slot_q; t_woff = '0; t_wlink = slot_q;
				end else if (poff_q) begin
					t_wl = 1'b1; t_wa = h_q; t_wlink = slot_q;
				end
			ffha_pkg::S_UL_PREV_WR:
				if (!p_none_q) begin
					t_wl = 1'b1; t_wa = p_q;
					t_wlink = (hlink_q == h_q) ? p_q : hlink_q;
				end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			len_q <= LW'(65536);
			used_q <= '0;
			first_empty_q <= 1'b1;
			first_q <= '0;
			unused_q <= LW'(65536);
		end else begin
			if (cfg_we) begin
				used_q <= '0;
				first_empty_q <= 1'b1;
				if (cfg_index == ffha_pkg::REG_HEAP_BASE) begin
					base_q <= cfg_data;
					unused_q <= len_q;
				end else begin
					if (CW'(cfg_data[LW-1:0]) > CAP) begin
						len_q <= LW'(CAP);
						unused_q <= LW'(CAP);
					end else begin
						len_q <= cfg_data[LW-1:0];
						unused_q <= cfg_data[LW-1:0];
					end
				end
			end
			case (state_q)
				ffha_pkg::S_RL_ROOM:
					if (gap_fit) unused_q <= unused_q + hlen_q - LW'(n_q);
				ffha_pkg::S_PL_FIRST_CHK:
					if (CW'(t_roff) >= n_q) begin
						first_q <= slot_q;
						used_q[slot_q] <= 1'b1;
						unused_q <= unused_q - LW'(n_q);
					end
				ffha_pkg::S_PL_CHK:
					if (gap_fit) begin
						used_q[slot_q] <= 1'b1;
						unused_q <= unused_q - LW'(n_q);
					end
				ffha_pkg::S_PL_WR:
					if (first_empty_q) begin
						first_empty_q <= 1'b0;
						first_q <= slot_q;
						used_q[slot_q] <= 1'b1;
						unused_q <= unused_q - LW'(n_q);
					end
				ffha_pkg::S_UL_PREV_WR: begin
					if (p_none_q) begin
						if (hlink_q == h_q) first_empty_q <= 1'b1;
						else first_q <= hlink_q;
					end
					used_q[h_q] <= 1'b0;
					unused_q <= unused_q + hlen_q;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ffha_pkg::S_IDLE:
				if (start) begin
					req_q <= req;
					rsp_q <= '0;
					second_q <= 1'b0;
				end
			ffha_pkg::S_DECODE: begin
				n_q <= bsize;
				slot_q <= fs;
				slot_ok_q <= fs_ok;
				h_q <= first_q;
				p_none_q <= 1'b1;
				cnt_q <= '0;
				rsp_q.status <= ffha_pkg::ST_OK;
				mode_q <= M_FREE;
				case (req_q.command)
					ffha_pkg::CMD_ALLOC, ffha_pkg::CMD_REALLOC:
						if (req_q.command == ffha_pkg::CMD_REALLOC
							&& !req_q.address_is_null) begin
							if (req_q.request_bytes == '0) begin
								if (first_empty_q) rsp_q.status <= ffha_pkg::ST_NOT_FOUND;
							end else if (bsize > CW'(unused_q)) begin
								rsp_q.status <= ffha_pkg::ST_NO_SPACE;
							end else begin
								mode_q <= M_REAL;
								if (first_empty_q) rsp_q.status <= ffha_pkg::ST_NOT_FOUND;
							end
						end else if (req_q.request_bytes == '0) begin
							rsp_q.status <= ffha_pkg::ST_NOOP;
						end else if (bsize > CW'(unused_q)) begin
							rsp_q.status <= ffha_pkg::ST_NO_SPACE;
						end else if (!fs_ok) begin
							rsp_q.status <= ffha_pkg::ST_FULL;
						end else begin
							rsp_q.status <= ffha_pkg::ST_NO_SPACE;
						end
					ffha_pkg::CMD_FREE:
						if (req_q.address_is_null) rsp_q.status <= ffha_pkg::ST_NOOP;
						else if (first_empty_q) rsp_q.status <= ffha_pkg::ST_NOT_FOUND;
					default: rsp_q.status <= ffha_pkg::ST_NOOP;
				endcase
			end
			ffha_pkg::S_FIND_RD: ;
			ffha_pkg::S_FIND_CHK: begin
				hoff_q <= t_roff;
				hlen_q <= t_rlen;
				hlink_q <= t_rlink;
				if (t_roff == tgt_off[OW-1:0] && tgt_off[AW-1:OW] == '0) begin
					if (mode_q == M_FREE) rsp_q.status <= ffha_pkg::ST_OK;
				end else if (t_rlink == h_q || cnt_q == (IW+1)'(MAX_BLOCKS - 1)) begin
					if (mode_q != M_UNLINK) rsp_q.status <= ffha_pkg::ST_NOT_FOUND;
				end else begin
					p_q <= h_q;
					p_none_q <= 1'b0;
					h_q <= t_rlink;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			ffha_pkg::S_RL_ROOM:
				if (gap_fit) begin
					rsp_q.status <= ffha_pkg::ST_OK;
					rsp_q.result_address <= base_q + AW'(hoff_q) + AW'(HEADER_BYTES);
				end else begin
					mode_q <= M_UNLINK;
					second_q <= 1'b1;
					rsp_q.status <= slot_ok_q ? ffha_pkg::ST_NO_SPACE : ffha_pkg::ST_FULL;
					h_q <= first_q;
					p_none_q <= 1'b1;
					cnt_q <= '0;
				end
			ffha_pkg::S_PL_FIRST_RD: begin
				poff_q <= 1'b0;
				if (first_empty_q) off_q <= '0;
				h_q <= first_q;
				hlink_q <= first_q;
				cnt_q <= '0;
			end
			ffha_pkg::S_PL_FIRST_CHK: begin
				hoff_q <= t_roff;
				hlen_q <= t_rlen;
				hlink_q <= t_rlink;
				if (CW'(t_roff) >= n_q) begin
					off_q <= '0;
					poff_q <= 1'b0;
					rsp_q.status <= ffha_pkg::ST_OK;
					rsp_q.result_address <= base_q + AW'(HEADER_BYTES);
					if (!second_q) rsp_q.granted_bytes <= LW'(n_q - HDR);
					else rsp_q.moved <= 1'b1;
				end
			end
			ffha_pkg::S_PL_RD: ;
			ffha_pkg::S_PL_CHK:
				if (gap_fit) begin
					off_q <= OW'(end_c);
					poff_q <= 1'b1;
					rsp_q.status <= ffha_pkg::ST_OK;
					rsp_q.result_address <= base_q + AW'(end_c) + AW'(HEADER_BYTES);
					if (!second_q) rsp_q.granted_bytes <= LW'(n_q - HDR);
					else rsp_q.moved <= 1'b1;
				end else if (last_c || cnt_q == (IW+1)'(MAX_BLOCKS - 1)) begin
					h_q <= first_q;
					p_none_q <= 1'b1;
					cnt_q <= '0;
				end else begin
					h_q <= hlink_q;
					hoff_q <= t_roff;
					hlen_q <= t_rlen;
					hlink_q <= t_rlink;
					cnt_q <= cnt_q + 1'b1;
				end
			ffha_pkg::S_PL_WR: begin
				if (first_empty_q) begin
					rsp_q.status <= ffha_pkg::ST_OK;
					rsp_q.result_address <= base_q + AW'(HEADER_BYTES);
					if (!second_q) rsp_q.granted_bytes <= LW'(n_q - HDR);
					else rsp_q.moved <= 1'b1;
				end
				if (second_q) begin
					mode_q <= M_UNLINK;
					h_q <= first_empty_q ? slot_q : first_q;
					p_none_q <= 1'b1;
					cnt_q <= '0;
				end
			end
			ffha_pkg::S_DONE: rsp_q.free_bytes <= unused_q;
			default: ;
		endcase
	end

	assign busy = (state_q != ffha_pkg::S_IDLE);

	logic done_q;
	ffha_pkg::rsp_t out_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ffha_pkg::S_DONE);
		end
	end
	always_ff @(posedge clk) begin
		if (state_q == ffha_pkg::S_DONE) begin
			out_q <= rsp_q;
			out_q.free_bytes <= unused_q;
		end
	end

	assign done = done_q;
	assign rsp  = out_q;
endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the first-fit heap allocator. Drives allocate, free, reallocate
// and no-op commands through the start/busy port, predicts every result with
// an independent model of the block list and checks each done strobe.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int NBLK = ffha_pkg::MAX_BLOCKS_DEF;
	localparam int HDR  = ffha_pkg::HEADER_BYTES_DEF;
	localparam int ALN  = ffha_pkg::ALIGN_BYTES_DEF;
	localparam int NONE = NBLK;
	localparam int LW   = ffha_pkg::LEN_W;

	logic                        clk;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	ffha_pkg::req_t              req;
	logic                        done;
	ffha_pkg::rsp_t              rsp;
	logic                        cfg_we;
	logic                        cfg_index;
	logic [ffha_pkg::ADDR_W-1:0] cfg_data;

	first_fit_heap_allocator_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.done     (done),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// heap shadow
	logic [31:0] base_addr;
	int unsigned arena_len;
	int unsigned blk_off [NBLK];
	int unsigned blk_len [NBLK];
	int unsigned blk_nxt [NBLK];
	bit          blk_used [NBLK];
	int unsigned head;
	int unsigned spare;

	ffha_pkg::rsp_t rsp_due [$];
	int   errors;
	logic [31:0] live_addr [$];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void heap_clear();
		foreach (blk_used[i]) blk_used[i] = 0;
		head  = NONE;
		spare = arena_len;
	endfunction

	function automatic int unsigned rounded(int unsigned r);
		return ((r + ALN - 1) / ALN) * ALN + HDR;
	endfunction

	function automatic int unsigned span(int unsigned a, int unsigned b);
		return (b >= a) ? b - a : 0;
	endfunction

	function automatic int unsigned open_slot();
		for (int i = 0; i < NBLK; i++)
			if (!blk_used[i]) return i;
		return NONE;
	endfunction

	function automatic int unsigned lookup(int unsigned off, output int unsigned prv);
		int unsigned h, p;
		h = head;
		p = NONE;
		prv = NONE;
		for (int i = 0; i < NBLK && h < NONE; i++) begin
			if (blk_off[h] == off) begin
				prv = p;
				return h;
			end
			if (blk_nxt[h] == h) break;
			p = h;
			h = blk_nxt[h];
		end
		return NONE;
	endfunction

	function automatic void detach(int unsigned h, int unsigned prv);
		bit tail;
		tail = (blk_nxt[h] == h);
		if (prv >= NONE) head = tail ? NONE : blk_nxt[h];
		else blk_nxt[prv] = tail ? prv : blk_nxt[h];
		blk_used[h] = 0;
		spare = (spare + blk_len[h]) & 21'h1FFFFF;
	endfunction

	function automatic bit fit(int unsigned n, int unsigned s, output int unsigned off_o);
		int unsigned h, e, nx, off;
		bit ok;
		off = 0;
		ok = 0;
		off_o = 0;
		if (head >= NONE) begin
			head = s;
			blk_nxt[s] = s;
			ok = 1;
		end else if (blk_off[head] >= n) begin
			blk_nxt[s] = head;
			head = s;
			ok = 1;
		end else begin
			h = head;
			for (int i = 0; i < NBLK; i++) begin
				e = blk_off[h] + blk_len[h];
				if (blk_nxt[h] != h) begin
					nx = blk_nxt[h];
					if (span(e, blk_off[nx]) >= n) begin
						blk_nxt[s] = nx;
						blk_nxt[h] = s;
						off = e;
						ok = 1;
						break;
					end
					h = nx;
				end else begin
					if (span(e, arena_len) >= n) begin
						blk_nxt[h] = s;
						blk_nxt[s] = s;
						off = e;
						ok = 1;
					end
					break;
				end
			end
		end
		if (!ok) return 0;
		blk_off[s] = off;
		blk_len[s] = n;
		blk_used[s] = 1;
		spare -= n;
		off_o = off;
		return 1;
	endfunction

	function automatic void grant(int unsigned r, ref ffha_pkg::rsp_t o);
		int unsigned n, s, off;
		if (r == 0) begin
			o.status = ffha_pkg::ST_NOOP;
			return;
		end
		n = rounded(r);
		if (n > spare) begin
			o.status = ffha_pkg::ST_NO_SPACE;
			return;
		end
		s = open_slot();
		if (s >= NONE) begin
			o.status = ffha_pkg::ST_FULL;
			return;
		end
		if (!fit(n, s, off)) begin
			o.status = ffha_pkg::ST_NO_SPACE;
			return;
		end
		o.status = ffha_pkg::ST_OK;
		o.result_address = base_addr + off + HDR;
		o.granted_bytes = LW'(n - HDR);
	endfunction

	function automatic void release_blk(int unsigned off, ref ffha_pkg::rsp_t o);
		int unsigned p, h;
		h = lookup(off, p);
		if (h >= NONE) begin
			o.status = ffha_pkg::ST_NOT_FOUND;
			return;
		end
		detach(h, p);
		o.status = ffha_pkg::ST_OK;
	endfunction

	function automatic void resize(int unsigned off, int unsigned r, ref ffha_pkg::rsp_t o);
		int unsigned n, p, h, room, s, noff;
		n = rounded(r);
		if (n > spare) begin
			o.status = ffha_pkg::ST_NO_SPACE;
			return;
		end
		h = lookup(off, p);
		if (h >= NONE) begin
			o.status = ffha_pkg::ST_NOT_FOUND;
			return;
		end
		room = (blk_nxt[h] != h) ? span(blk_off[h], blk_off[blk_nxt[h]])
			: span(blk_off[h], arena_len);
		if (room >= n) begin
			spare = spare + blk_len[h] - n;
			blk_len[h] = n;
			o.status = ffha_pkg::ST_OK;
			o.result_address = base_addr + blk_off[h] + HDR;
			return;
		end
		s = open_slot();
		if (s >= NONE) o.status = ffha_pkg::ST_FULL;
		else if (fit(n, s, noff)) begin
			o.status = ffha_pkg::ST_OK;
			o.result_address = base_addr + noff + HDR;
			o.moved = 1'b1;
		end else o.status = ffha_pkg::ST_NO_SPACE;
		h = lookup(off, p);
		if (h < NONE) detach(h, p);
	endfunction

	function automatic ffha_pkg::rsp_t predict_heap(ffha_pkg::req_t r);
		ffha_pkg::rsp_t o;
		logic [31:0] off;
		o = '0;
		off = r.payload_address - HDR - base_addr;
		case (r.command)
			ffha_pkg::CMD_ALLOC: grant(r.request_bytes, o);
			ffha_pkg::CMD_FREE: begin
				if (r.address_is_null) o.status = ffha_pkg::ST_NOOP;
				else release_blk(off, o);
			end
			ffha_pkg::CMD_REALLOC: begin
				if (r.address_is_null) grant(r.request_bytes, o);
				else if (r.request_bytes == 0) release_blk(off, o);
				else resize(off, r.request_bytes, o);
			end
			default: o.status = ffha_pkg::ST_NOOP;
		endcase
		o.free_bytes = LW'(spare);
		return o;
	endfunction

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if (n != 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_cmd(ffha_pkg::cmd_t c, bit nul, logic [31:0] a, int unsigned r,
		bit gaps = 1);
		ffha_pkg::req_t it;
		ffha_pkg::rsp_t e;
		it.command = c;
		it.address_is_null = nul;
		it.payload_address = a;
		it.request_bytes = r[LW-1:0];
		if (gaps) idle_gap();
		start <= 1'b1;
		req <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		e = predict_heap(it);
		rsp_due.push_back(e);
		if (e.status == ffha_pkg::ST_OK && e.result_address != 0)
			live_addr.push_back(e.result_address);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		start <= 1'b0;
		while (rsp_due.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (6 * NBLK + 20) @(posedge clk);
	endtask

	task automatic write_reg(ffha_pkg::reg_idx_t idx, logic [31:0] v);
		logic [31:0] cl;
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == ffha_pkg::REG_HEAP_BASE) base_addr = v;
		else begin
			cl = v & 32'h1FFFFF;
			arena_len = (cl > (1 << ffha_pkg::ARENA_ADDR_BITS_DEF))
				? (1 << ffha_pkg::ARENA_ADDR_BITS_DEF) : cl;
		end
		heap_clear();
		live_addr.delete();
	endtask

	function automatic logic [31:0] pick_addr();
		if (live_addr.size() != 0 && $urandom_range(0, 4) != 0)
			return live_addr[$urandom_range(0, live_addr.size() - 1)];
		return $urandom();
	endfunction

	always @(posedge clk) begin
		ffha_pkg::rsp_t e;
		if (done) begin
			if (rsp_due.size() == 0) begin
				$error("result with no expectation");
				errors++;
			end else begin
				e = rsp_due.pop_front();
				if (rsp.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, rsp.status); errors++;
				end
				if (rsp.result_address !== e.result_address) begin
					$error("result_address exp %h got %h", e.result_address,
						rsp.result_address); errors++;
				end
				if (rsp.granted_bytes !== e.granted_bytes) begin
					$error("granted_bytes exp %0d got %0d", e.granted_bytes,
						rsp.granted_bytes); errors++;
				end
				if (rsp.moved !== e.moved) begin
					$error("moved exp %0d got %0d", e.moved, rsp.moved); errors++;
				end
				if (rsp.free_bytes !== e.free_bytes) begin
					$error("free_bytes exp %0d got %0d", e.free_bytes, rsp.free_bytes);
					errors++;
				end
			end
		end
	end

	task automatic test_special_cases();
		logic [31:0] a;
		send_cmd(ffha_pkg::CMD_NOP, 0, 32'hFFFF_FFFF, 21'h1FFFFF);
		send_cmd(ffha_pkg::CMD_ALLOC, 0, 0, 0);
		send_cmd(ffha_pkg::CMD_FREE, 1, 0, 5);
		send_cmd(ffha_pkg::CMD_FREE, 0, 32'h1234, 0);
		send_cmd(ffha_pkg::CMD_ALLOC, 0, 0, 21'h1FFFFF);
		send_cmd(ffha_pkg::CMD_ALLOC, 0, 0, 1);
		a = base_addr + HDR;
		send_cmd(ffha_pkg::CMD_ALLOC, 0, 0, 100);
		send_cmd(ffha_pkg::CMD_REALLOC, 1, 0, 7);
		send_cmd(ffha_pkg::CMD_REALLOC, 0, a, 3);
		send_cmd(ffha_pkg::CMD_REALLOC, 0, a, 200);
		send_cmd(ffha_pkg::CMD_REALLOC, 0, a + 500, 10);
		send_cmd(ffha_pkg::CMD_REALLOC, 0, base_addr + 20, 0);
		send_cmd(ffha_pkg::CMD_REALLOC, 0, base_addr + 20, 0);
		send_cmd(ffha_pkg::CMD_ALLOC, 0, 0, 4);
		send_cmd(ffha_pkg::CMD_ALLOC, 0, 0, arena_len - 400);
		send_cmd(ffha_pkg::CMD_FREE, 0, a, 0);
	endtask

	task automatic test_table_full();
		write_reg(ffha_pkg::REG_HEAP_LENGTH, 32'd4000);
		for (int i = 0; i < NBLK + 2; i++)
			send_cmd(ffha_pkg::CMD_ALLOC, 0, 0, 4, i % 3 == 0);
		send_cmd(ffha_pkg::CMD_REALLOC, 0, base_addr + HDR, 1000);
		send_cmd(ffha_pkg::CMD_REALLOC, 0, base_addr + 3 * 12 + HDR, 2000);
		send_cmd(ffha_pkg::CMD_FREE, 0, base_addr + 5 * 12 + HDR, 0);
		send_cmd(ffha_pkg::CMD_ALLOC, 0, 0, 8);
		send_cmd(ffha_pkg::CMD_ALLOC, 0, 0, 4);
	endtask

	task automatic random_phase(int n, int unsigned maxreq);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 40) send_cmd(ffha_pkg::CMD_ALLOC, 0, $urandom(),
				$urandom_range(1, maxreq));
			else if (k < 65) send_cmd(ffha_pkg::CMD_FREE, $urandom_range(0, 15) == 0,
				pick_addr(), $urandom_range(0, 21'h1FFFFF));
			else if (k < 92) send_cmd(ffha_pkg::CMD_REALLOC, $urandom_range(0, 15) == 0,
				pick_addr(), ($urandom_range(0, 10) == 0) ? 0 : $urandom_range(1, maxreq));
			else if (k < 96) send_cmd(ffha_pkg::CMD_ALLOC, 0, $urandom(),
				$urandom_range(0, 21'h1FFFFF));
			else send_cmd(ffha_pkg::CMD_NOP, $urandom_range(0, 1), $urandom(),
				$urandom_range(0, 21'h1FFFFF));
		end
	endtask

	task automatic test_random_settings();
		write_reg(ffha_pkg::REG_HEAP_BASE, $urandom());
		write_reg(ffha_pkg::REG_HEAP_LENGTH, 32'd3000);
		random_phase(200, 300);
		write_reg(ffha_pkg::REG_HEAP_BASE, 32'hFFFF_FFF0);
		write_reg(ffha_pkg::REG_HEAP_LENGTH, 32'h1F_FFFF);
		random_phase(150, 60000);
		write_reg(ffha_pkg::REG_HEAP_BASE, 32'h0);
		write_reg(ffha_pkg::REG_HEAP_LENGTH, 32'd0);
		random_phase(30, 40);
		write_reg(ffha_pkg::REG_HEAP_LENGTH, 32'd1048576);
		random_phase(120, 4000);
		write_reg(ffha_pkg::REG_HEAP_BASE, 32'h8000_0000);
		write_reg(ffha_pkg::REG_HEAP_LENGTH, 32'd65536);
		random_phase(150, 1500);
	endtask

	initial begin
		clk = 1'b0;
		errors = 0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		base_addr = 0;
		arena_len = 65536;
		heap_clear();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_cases();
		test_table_full();
		test_random_settings();
		drain();
		if (rsp_due.size() != 0) begin
			$error("expectations left over: %0d", rsp_due.size());
			errors++;
		end
		if (errors == 0) $display("tb_top: done, clean");
		else $display("tb_top: done, errors");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
